### hw/rtl/miller_rabin_round_core_defines.svh
// Assertion macros for the Miller-Rabin round core.
`ifndef MILLER_RABIN_ROUND_CORE_DEFINES_SVH
`define MILLER_RABIN_ROUND_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/mrr_pkg.sv
// Shared types for the Miller-Rabin round core.
package mrr_pkg;
   typedef enum logic [1:0] {
      MRR_OP_MUL,
      MRR_OP_MOD
   } mrr_op_type;

   typedef struct packed {
      logic start;
      mrr_op_type op;
   } mrr_unit_ctl_type;
endpackage

### hw/rtl/mrr_modmul.sv
// Shared bit-serial modular unit: x*y mod m (double and add) or x mod m (restoring).
module mrr_modmul #(
   parameter int W = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mrr_pkg::mrr_unit_ctl_type ctl,
   input  logic [W-1:0]              x,
   input  logic [W-1:0]              y,
   input  logic [W-1:0]              m,
   output logic                      done,
   output logic [W-1:0]              result
);
   import mrr_pkg::*;
   localparam int CW = $clog2(W + 1);

   logic             run_ff, run_in;
   mrr_op_type       op_ff, op_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     mul_ff, mul_in;
   logic [W-1:0]     mod_ff, mod_in;
   logic             done_ff, done_in;
   logic [W:0]       sum_a, sum_b, rem2;

   always_comb begin
      run_in  = run_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      mul_in  = mul_ff;
      mod_in  = mod_ff;
      done_in = 1'b0;
      sum_a   = {1'b0, acc_ff} + {1'b0, base_ff};
      sum_b   = {1'b0, base_ff} + {1'b0, base_ff};
      // restoring remainder: acc*2 + next bit of mul
      rem2    = {acc_ff, mul_ff[W-1]};
      if (ctl.start) begin
         run_in  = 1'b1;
         op_in   = ctl.op;
         cnt_in  = CW'(W);
         acc_in  = '0;
         base_in = x;
         mul_in  = (ctl.op == MRR_OP_MUL) ? y : x;
         mod_in  = m;
      end else if (run_ff) begin
         unique case (op_ff)
            MRR_OP_MUL: begin
               if (mul_ff[0])
                  acc_in = (sum_a >= {1'b0, mod_ff}) ? W'(sum_a - {1'b0, mod_ff}) : W'(sum_a);
               base_in = (sum_b >= {1'b0, mod_ff}) ? W'(sum_b - {1'b0, mod_ff}) : W'(sum_b);
               mul_in  = mul_ff >> 1;
            end
            default: begin
               acc_in = (rem2 >= {1'b0, mod_ff}) ? W'(rem2 - {1'b0, mod_ff}) : W'(rem2);
               mul_in = mul_ff << 1;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= MRR_OP_MUL;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
      mul_ff  <= mul_in;
      mod_ff  <= mod_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule

### hw/rtl/miller_rabin_round_core.sv
// Top level of the Miller-Rabin single-witness round core.
//  channel   | direction | handshake             | payload
//  request   | in        | req_start / req_busy  | req_candidate, req_witness
//  response  | out       | rsp_valid (1 cycle)   | rsp_probable_prime, rsp_decided_without_witness
// Sequence: trivial candidates are answered without the witness. Otherwise
// one reduction of the witness, then up to 2 modular products per exponent bit plus
// up to s-1 squarings, each made of an issue state, W steps in the shared
// bit-serial unit and the capture in the wait state.
// Reset: synchronous, active high; clears the sequencer and the control of the modular unit only.
// Stalls: busy is high from acceptance until the response cycle; the
// receiver cannot stall the response.
module miller_rabin_round_core #(
   parameter int VALUE_BITS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   output logic                  req_busy,
   input  logic [VALUE_BITS-1:0] req_candidate,
   input  logic [VALUE_BITS-1:0] req_witness,
   output logic                  rsp_valid,
   output logic                  rsp_probable_prime,
   output logic                  rsp_decided_without_witness
);
   import mrr_pkg::*;
   `include "miller_rabin_round_core_defines.svh"

   localparam int W  = VALUE_BITS;
   localparam int SW = $clog2(W + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPLIT, ST_RED, ST_REDW, ST_CHECKA, ST_PMUL, ST_PMULW,
      ST_PSQ, ST_PSQW, ST_CHECKX, ST_SQ, ST_SQW, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [W-1:0]     n_ff, n_in;
   logic [W-1:0]     a_ff, a_in;     // witness, later running base
   logic [W-1:0]     d_ff, d_in;     // remaining exponent
   logic [W-1:0]     x_ff, x_in;
   logic [SW-1:0]    s_ff, s_in;     // factors of two in n-1; squarings left plus one
   logic             prime_ff, prime_in;
   logic             direct_ff, direct_in;
   logic             valid_ff, valid_in;
   mrr_unit_ctl_type ctl;
   logic [W-1:0]     ux, uy;
   logic             udone;
   logic [W-1:0]     ures;
   logic [W-1:0]     nm1;

   assign nm1 = n_ff - 1'b1;

   mrr_modmul #(.W(W)) u_modmul (
      .clock(clock), .reset(reset), .ctl(ctl), .x(ux), .y(uy), .m(n_ff),
      .done(udone), .result(ures)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      a_in      = a_ff;
      d_in      = d_ff;
      x_in      = x_ff;
      s_in      = s_ff;
      prime_in  = prime_ff;
      direct_in = direct_ff;
      valid_in  = 1'b0;
      ctl.start = 1'b0;
      ctl.op    = MRR_OP_MUL;
      ux        = x_ff;
      uy        = a_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               n_in      = req_candidate;
               a_in      = req_witness;
               prime_in  = 1'b0;
               direct_in = 1'b0;
               state_in  = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (n_ff <= W'(1) || !n_ff[0]) begin
               prime_in  = (n_ff == W'(2));
               direct_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               d_in     = nm1 >> 1;
               s_in     = SW'(1);
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            // strip factors of two from d, one per cycle
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               ctl.start = 1'b1;
               ctl.op    = MRR_OP_MOD;
               ux        = a_ff;
               state_in  = ST_REDW;
            end
         end
         ST_REDW: begin
            ux = a_ff;
            if (udone) begin
               a_in     = ures;
               x_in     = W'(1);
               state_in = ST_CHECKA;
            end
         end
         ST_CHECKA: begin
            if (a_ff <= W'(1) || a_ff == nm1) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            if (d_ff == '0) begin
               state_in = ST_CHECKX;
            end else if (d_ff[0]) begin
               ctl.start = 1'b1;
               state_in  = ST_PMULW;
            end else begin
               state_in = ST_PSQ;
            end
         end
         ST_PMULW: begin
            if (udone) begin
               x_in     = ures;
               state_in = ST_PSQ;
            end
         end
         ST_PSQ: begin
            ctl.start = 1'b1;
            ux        = a_ff;
            state_in  = ST_PSQW;
         end
         ST_PSQW: begin
            if (udone) begin
               a_in     = ures;
               d_in     = d_ff >> 1;
               state_in = ST_PMUL;
            end
         end
         ST_CHECKX: begin
            if (x_ff == W'(1) || x_ff == nm1) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (s_ff <= SW'(1)) begin
               state_in = ST_DONE;
            end else begin
               ctl.start = 1'b1;
               uy        = x_ff;
               state_in  = ST_SQW;
            end
         end
         ST_SQW: begin
            if (udone) begin
               x_in = ures;
               s_in = s_ff - 1'b1;
               if (ures == nm1) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      n_ff      <= n_in;
      a_ff      <= a_in;
      d_ff      <= d_in;
      x_ff      <= x_in;
      s_ff      <= s_in;
      prime_ff  <= prime_in;
      direct_ff <= direct_in;
   end

   assign req_busy                    = (state_ff != ST_IDLE);
   assign rsp_valid                   = valid_ff;
   assign rsp_probable_prime          = prime_ff;
   assign rsp_decided_without_witness = direct_ff;

   `MR_ASSERT_NEXT(a_start_busy, clock, reset, req_start && !req_busy, req_busy)
   `MR_ASSERT_IMPL(a_valid_idle, clock, reset, rsp_valid, !req_busy)
   `MR_ASSERT_IMPL(a_direct_even, clock, reset, rsp_valid && rsp_decided_without_witness && rsp_probable_prime, n_ff == W'(2))
endmodule
